### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the semaphore table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BST_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define BST_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/core/bst_pkg.sv
// Types, codes and helpers for the binary semaphore table
package bst_pkg;

  localparam int GRP_W = 32;
  localparam int OFF_W = 5;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_DOWN  = 2'd2,
    OP_UP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_WOULD_BLOCK = 2'd1,
    ST_FULL        = 2'd2,
    ST_RANGE       = 2'd3
  } status_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  // offset of the lowest clear bit in a group
  function automatic logic [OFF_W-1:0] first_zero(input logic [GRP_W-1:0] v);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = OFF_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/bst_in_if.sv
// Request channel of the semaphore table
interface bst_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] sem_index;

  modport source (output valid, output operation, output sem_index, input ready);
  modport sink   (input valid, input operation, input sem_index, output ready);
endinterface

### rtl/core/bst_out_if.sv
// Result channel of the semaphore table
interface bst_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] granted_index;
  logic [1:0] status;
  logic       wake_waiters;

  modport source (output valid, output granted_index, output status, output wake_waiters,
                  input ready);
  modport sink   (input valid, input granted_index, input status, input wake_waiters,
                  output ready);
endinterface

### rtl/core/bst_ctrl.sv
// Sequencing FSM: request capture, update step and result valid
module bst_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output bst_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept      = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign cmd.capture = accept;
  assign cmd.exec    = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/bst_datapath.sv
// Occupancy bits, free-search summaries, lock-bit memory and result register
module bst_datapath #(
  parameter int SEM_COUNT = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bst_pkg::cmd_t cmd,
  input  logic [1:0]    in_operation,
  input  logic [7:0]    in_sem_index,
  output logic [6:0]    out_granted_index,
  output logic [1:0]    out_status,
  output logic          out_wake_waiters
);

  localparam int IDX_W  = $clog2(SEM_COUNT);
  localparam int NGRP   = (SEM_COUNT + bst_pkg::GRP_W - 1) / bst_pkg::GRP_W;
  localparam int PAD    = NGRP * bst_pkg::GRP_W;
  localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int CMP_W  = ((IDX_W > 8) ? IDX_W : 8) + 1;
  localparam int MEM_D  = 1 << IDX_W;

  logic [SEM_COUNT-1:0]        occ_r;
  logic [PAD-1:0]              occ_pad;
  logic [NGRP-1:0]             grp_free_r;
  logic [bst_pkg::OFF_W-1:0]   grp_off_r [NGRP];
  logic                        unl_mem [MEM_D];
  logic                        unl_rd_r;
  bst_pkg::op_t                op_r;
  logic [7:0]                  idx_r;
  logic [6:0]                  gi_r;
  bst_pkg::status_t            st_r;
  logic                        wk_r;

  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            idx_addr;
  logic                        idx_ok;
  logic [GSEL_W-1:0]           gsel;
  logic                        any_free;
  logic [IDX_W-1:0]            alloc_idx;
  logic                        occ_hit;

  logic                        occ_we;
  logic                        occ_wd;
  logic [IDX_W-1:0]            wr_addr;
  logic                        mem_we;
  logic                        mem_wd;
  logic [6:0]                  gi_nxt;
  bst_pkg::status_t            st_nxt;
  logic                        wk_nxt;

  // pad bits past the table read as occupied
  for (genvar i = 0; i < PAD; i++) begin : g_pad
    if (i < SEM_COUNT) begin : g_real
      assign occ_pad[i] = occ_r[i];
    end else begin : g_fill
      assign occ_pad[i] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_free_r <= '1;
      for (int g = 0; g < NGRP; g++) begin
        grp_off_r[g] <= '0;
      end
    end else begin
      for (int g = 0; g < NGRP; g++) begin
        grp_free_r[g] <= ~&occ_pad[g*bst_pkg::GRP_W +: bst_pkg::GRP_W];
        grp_off_r[g]  <= bst_pkg::first_zero(occ_pad[g*bst_pkg::GRP_W +: bst_pkg::GRP_W]);
      end
    end
  end

  always_comb begin
    gsel     = '0;
    any_free = 1'b0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        any_free = 1'b1;
        gsel     = GSEL_W'(g);
      end
    end
  end

  assign alloc_idx = IDX_W'({gsel, grp_off_r[gsel]});
  assign rd_addr   = IDX_W'(in_sem_index);
  assign idx_addr  = IDX_W'(idx_r);
  assign idx_ok    = CMP_W'(idx_r) < CMP_W'(SEM_COUNT);
  assign occ_hit   = occ_r[idx_addr];

  always_comb begin
    occ_we  = 1'b0;
    occ_wd  = 1'b0;
    wr_addr = idx_addr;
    mem_we  = 1'b0;
    mem_wd  = 1'b0;
    gi_nxt  = '0;
    st_nxt  = bst_pkg::ST_OK;
    wk_nxt  = 1'b0;
    if (op_r == bst_pkg::OP_ALLOC) begin
      wr_addr = alloc_idx;
      if (any_free) begin
        occ_we = 1'b1;
        occ_wd = 1'b1;
        mem_we = 1'b1;
        mem_wd = 1'b1;
        gi_nxt = 7'(alloc_idx);
      end else begin
        st_nxt = bst_pkg::ST_FULL;
      end
    end else if (!idx_ok) begin
      st_nxt = bst_pkg::ST_RANGE;
    end else begin
      case (op_r)
        bst_pkg::OP_FREE: begin
          occ_we = 1'b1;
        end
        bst_pkg::OP_DOWN: begin
          if (occ_hit) begin
            if (unl_rd_r) begin
              mem_we = 1'b1;
            end else begin
              st_nxt = bst_pkg::ST_WOULD_BLOCK;
            end
          end
        end
        bst_pkg::OP_UP: begin
          if (occ_hit) begin
            mem_we = 1'b1;
            mem_wd = 1'b1;
            wk_nxt = 1'b1;
          end
        end
        default: begin
          st_nxt = bst_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.exec && occ_we) begin
      occ_r[wr_addr] <= occ_wd;
    end
  end

  // lock bits: one read at capture, one write at update
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      unl_rd_r <= unl_mem[rd_addr];
    end
    if (cmd.exec && mem_we) begin
      unl_mem[wr_addr] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= bst_pkg::op_t'(in_operation);
      idx_r <= in_sem_index;
    end
    if (cmd.exec) begin
      gi_r <= gi_nxt;
      st_r <= st_nxt;
      wk_r <= wk_nxt;
    end
  end

  assign out_granted_index = gi_r;
  assign out_status        = st_r;
  assign out_wake_waiters  = wk_r;

endmodule

### rtl/core/binary_semaphore_table.sv
// Binary semaphore table top level: alloc, free, try-down and up on SEM_COUNT entries.
// For each request, the accept cycle registers the request and reads the lock
// bit of the addressed entry from its single-port memory, and the following cycle finds
// the lowest free entry from registered per-32-entry occupancy summaries, updates the
// occupancy and lock bits and loads the result register. A new request is taken only
// after that update and while the result of the previous one has been taken or is taken
// in the same cycle. Lock bits are undefined until an alloc writes them; occupancy clears
// on reset with no clearing pass. Non-alloc ops on entries >= SEM_COUNT report out of range.
`include "assert_macros.svh"

module binary_semaphore_table #(
  parameter int SEM_COUNT = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  bst_in_if.sink    in_ch,
  bst_out_if.source out_ch
);

  bst_pkg::cmd_t cmd;

  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bst_datapath #(
    .SEM_COUNT (SEM_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_ch.operation),
    .in_sem_index      (in_ch.sem_index),
    .out_granted_index (out_ch.granted_index),
    .out_status        (out_ch.status),
    .out_wake_waiters  (out_ch.wake_waiters)
  );

  // busy during the update step
  `BST_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // result is up once the update step that follows the request beat is done
  `BST_ASSERT_NEXT(a_result_follows, in_ch.valid && in_ch.ready, ##1 out_ch.valid)
  // failures carry no descriptor and no wake
  `BST_ASSERT_SAME(a_fail_fields, out_ch.valid && out_ch.status != bst_pkg::ST_OK,
                   out_ch.granted_index == 7'd0 && !out_ch.wake_waiters)

endmodule

### verif/tb_binary_semaphore_table.sv
// Self-checking testbench for binary_semaphore_table: directed and random requests with checks
module tb_binary_semaphore_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEM_COUNT = 128;
  localparam int N_RANDOM  = 1400;
  localparam int BATCH     = 8;

  typedef struct {
    bst_pkg::op_t op;
    logic [7:0]   idx;
  } sem_req_t;

  typedef struct {
    logic [6:0]       grant;
    bst_pkg::status_t status;
    logic             wake;
  } sem_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bst_in_if  req_bus ();
  bst_out_if rsp_bus ();

  binary_semaphore_table #(
    .SEM_COUNT(SEM_COUNT)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_bus),
    .out_ch(rsp_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sem_req_t req_queue[$];
  sem_rsp_t rsp_expect[$];
  sem_req_t req_live;
  bit       sem_busy[SEM_COUNT];
  bit       sem_open[SEM_COUNT];
  int       n_gen   = 0;
  int       n_taken = 0;
  int       n_bad   = 0;
  bit       calm    = 1'b0;

  initial begin
    req_bus.valid     = 1'b0;
    req_bus.operation = bst_pkg::OP_ALLOC;
    req_bus.sem_index = '0;
    rsp_bus.ready     = 1'b0;
  end

  // table state update and the result one request should give
  function automatic sem_rsp_t sem_table_apply(input sem_req_t r);
    sem_rsp_t o;
    int       slot;
    o.grant  = '0;
    o.status = bst_pkg::ST_OK;
    o.wake   = 1'b0;
    slot     = -1;
    if (r.op == bst_pkg::OP_ALLOC) begin
      for (int i = SEM_COUNT - 1; i >= 0; i--) begin
        if (!sem_busy[i]) begin
          slot = i;
        end
      end
      if (slot < 0) begin
        o.status = bst_pkg::ST_FULL;
      end else begin
        sem_busy[slot] = 1'b1;
        sem_open[slot] = 1'b1;
        o.grant        = 7'(slot);
      end
    end else if (r.idx >= SEM_COUNT) begin
      o.status = bst_pkg::ST_RANGE;
    end else if (r.op == bst_pkg::OP_FREE) begin
      sem_busy[r.idx] = 1'b0;
    end else if (r.op == bst_pkg::OP_DOWN) begin
      if (sem_busy[r.idx]) begin
        if (sem_open[r.idx]) begin
          sem_open[r.idx] = 1'b0;
        end else begin
          o.status = bst_pkg::ST_WOULD_BLOCK;
        end
      end
    end else if (sem_busy[r.idx]) begin
      sem_open[r.idx] = 1'b1;
      o.wake          = 1'b1;
    end
    return o;
  endfunction

  task automatic queue_req(input bst_pkg::op_t op, input logic [7:0] idx);
    sem_req_t r;
    r.op  = op;
    r.idx = idx;
    req_queue.push_back(r);
    n_gen++;
  endtask

  // one batch drawn against the current table contents
  task automatic gen_batch(input int alloc_pct, input int free_pct);
    int           held[$];
    int           roll;
    bst_pkg::op_t op;
    logic [7:0]   idx;
    while (n_taken != n_gen) @(posedge clk);
    for (int i = 0; i < SEM_COUNT; i++) begin
      if (sem_busy[i]) begin
        held.push_back(i);
      end
    end
    repeat (BATCH) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        op = bst_pkg::OP_ALLOC;
      end else if (roll < alloc_pct + free_pct) begin
        op = bst_pkg::OP_FREE;
      end else if ($urandom_range(1) == 0) begin
        op = bst_pkg::OP_DOWN;
      end else begin
        op = bst_pkg::OP_UP;
      end
      roll = $urandom_range(99);
      if (op == bst_pkg::OP_ALLOC || roll < 10) begin
        idx = 8'($urandom_range(255));
      end else if (roll < 20) begin
        idx = 8'($urandom_range(255, SEM_COUNT));
      end else if (roll < 30 || held.size() == 0) begin
        idx = 8'($urandom_range(SEM_COUNT - 1));
      end else begin
        idx = 8'(held[$urandom_range(held.size() - 1)]);
      end
      queue_req(op, idx);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        rsp_expect.push_back(sem_table_apply(req_live));
        n_taken++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (req_queue.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          req_live = req_queue.pop_front();
          req_bus.valid     <= 1'b1;
          req_bus.operation <= req_live.op;
          req_bus.sem_index <= req_live.idx;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    sem_rsp_t want;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (rsp_expect.size() == 0) begin
          n_bad++;
          $display("%0t: result beat with nothing expected: grant %0d status %0d wake %0b",
                   $time, rsp_bus.granted_index, rsp_bus.status, rsp_bus.wake_waiters);
        end else begin
          want = rsp_expect.pop_front();
          if (rsp_bus.granted_index !== want.grant) begin
            n_bad++;
            $display("%0t: granted_index expected %0d actual %0d",
                     $time, want.grant, rsp_bus.granted_index);
          end
          if (rsp_bus.status !== want.status) begin
            n_bad++;
            $display("%0t: status expected %0d (%s) actual %0d",
                     $time, want.status, want.status.name(), rsp_bus.status);
          end
          if (rsp_bus.wake_waiters !== want.wake) begin
            n_bad++;
            $display("%0t: wake_waiters expected %0b actual %0b",
                     $time, want.wake, rsp_bus.wake_waiters);
          end
        end
      end
      rsp_bus.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  initial begin
    int mode;
    int seg_len;
    int stop_at;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // untouched table: ops on free entries and bad descriptors
    queue_req(bst_pkg::OP_DOWN, 8'd0);
    queue_req(bst_pkg::OP_UP, 8'd5);
    queue_req(bst_pkg::OP_FREE, 8'd3);
    queue_req(bst_pkg::OP_UP, 8'd127);
    queue_req(bst_pkg::OP_FREE, 8'd128);
    queue_req(bst_pkg::OP_DOWN, 8'd255);
    queue_req(bst_pkg::OP_UP, 8'd200);
    // alloc ignores the index
    queue_req(bst_pkg::OP_ALLOC, 8'd255);
    queue_req(bst_pkg::OP_ALLOC, 8'd0);
    queue_req(bst_pkg::OP_ALLOC, 8'd127);
    // lock, would-block, wake, wake while already unlocked
    queue_req(bst_pkg::OP_DOWN, 8'd0);
    queue_req(bst_pkg::OP_DOWN, 8'd0);
    queue_req(bst_pkg::OP_UP, 8'd0);
    queue_req(bst_pkg::OP_UP, 8'd0);
    queue_req(bst_pkg::OP_DOWN, 8'd0);
    // freeing keeps the lock bit; realloc unlocks it
    queue_req(bst_pkg::OP_DOWN, 8'd1);
    queue_req(bst_pkg::OP_FREE, 8'd1);
    queue_req(bst_pkg::OP_FREE, 8'd1);
    queue_req(bst_pkg::OP_DOWN, 8'd1);
    queue_req(bst_pkg::OP_UP, 8'd1);
    queue_req(bst_pkg::OP_ALLOC, 8'd128);
    queue_req(bst_pkg::OP_DOWN, 8'd1);
    queue_req(bst_pkg::OP_FREE, 8'd0);
    queue_req(bst_pkg::OP_DOWN, 8'd0);
    queue_req(bst_pkg::OP_FREE, 8'd255);

    stop_at = n_gen + N_RANDOM;
    mode    = 0;
    while (n_gen < stop_at) begin
      seg_len = (mode == 0) ? 20 : 12;
      repeat (seg_len) begin
        calm = (n_gen >= 700 && n_gen < 1000);
        case (mode)
          0: gen_batch(80, 5);
          1: gen_batch(30, 25);
          2: gen_batch(5, 60);
          default: gen_batch(15, 10);
        endcase
      end
      mode = $urandom_range(3);
    end

    while (n_taken != n_gen || rsp_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0) begin
      $display("[binary_semaphore_table] OK");
    end else begin
      $display("[binary_semaphore_table] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[binary_semaphore_table] ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bst_pkg.sv
rtl/core/bst_in_if.sv
rtl/core/bst_out_if.sv
rtl/core/bst_ctrl.sv
rtl/core/bst_datapath.sv
rtl/core/binary_semaphore_table.sv
verif/tb_binary_semaphore_table.sv
